FILE: sv/assert_macros.svh
// Assertion helpers; clk_i and rst_ni must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define PMCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold.
`define PMCT_ASSERT_NEVER(lbl, expr, msg) \
  `PMCT_ASSERT(lbl, !(expr), msg)

`endif

FILE: sv/pmct_pkg.sv
`default_nettype none
package pmct_pkg;

  localparam int CNT_W   = 11;  // visible counts wrap at this width
  localparam int HGT_W   = 32;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [PADDR_W-3:0] REG_POSITIONS = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DOWN,
    S_POP,
    S_UPISS,
    S_UPRD,
    S_CAISS,
    S_CAEVAL,
    S_UPWR,
    S_VISIT,
    S_QISS,
    S_QMAX,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_DOWN,
    CMD_LEAF,
    CMD_POP,
    CMD_UPISS,
    CMD_UPRD,
    CMD_CAISS,
    CMD_CAEVAL,
    CMD_UPWR,
    CMD_VISIT,
    CMD_QISS,
    CMD_QMAX,
    CMD_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic cfg_wr;      // positions register written this cycle
    logic clr_last;    // last entry of the clearing sweep
    logic in_query;    // offered item is a query
    logic req_ok;      // offered write in range / offered query range not empty
    logic cur_query;   // item in progress is a query
    logic lo_eq_hi;    // current node is a leaf
    logic sp_zero;     // path stack empty
    logic ca_done;     // visible-count walk finishes this cycle
    logic full_cover;  // current node lies inside the query range
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/pmct_ctrl.sv
`default_nettype none
module pmct_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire pmct_pkg::sts_t sts_i,
  output pmct_pkg::cmd_t     cmd_o,
  output logic               in_ready_o
);

  pmct_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmct_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pmct_pkg::S_CLEAR:  if (sts_i.clr_last) state_d = pmct_pkg::S_IDLE;
      pmct_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_query) begin
            state_d = sts_i.req_ok ? pmct_pkg::S_VISIT : pmct_pkg::S_DONE;
          end else if (sts_i.req_ok) begin
            state_d = pmct_pkg::S_DOWN;
          end
        end
      end
      pmct_pkg::S_DOWN: begin
        if (sts_i.lo_eq_hi) begin
          state_d = sts_i.sp_zero ? pmct_pkg::S_IDLE : pmct_pkg::S_POP;
        end
      end
      pmct_pkg::S_POP:    state_d = pmct_pkg::S_UPISS;
      pmct_pkg::S_UPISS:  state_d = pmct_pkg::S_UPRD;
      pmct_pkg::S_UPRD:   state_d = pmct_pkg::S_CAISS;
      pmct_pkg::S_CAISS:  state_d = pmct_pkg::S_CAEVAL;
      pmct_pkg::S_CAEVAL: begin
        if (!sts_i.ca_done) begin
          state_d = pmct_pkg::S_CAISS;
        end else begin
          state_d = sts_i.cur_query ? pmct_pkg::S_QISS : pmct_pkg::S_UPWR;
        end
      end
      pmct_pkg::S_UPWR:   state_d = sts_i.sp_zero ? pmct_pkg::S_IDLE : pmct_pkg::S_POP;
      pmct_pkg::S_VISIT:  if (sts_i.full_cover) state_d = pmct_pkg::S_CAISS;
      pmct_pkg::S_QISS:   state_d = pmct_pkg::S_QMAX;
      pmct_pkg::S_QMAX:   state_d = sts_i.sp_zero ? pmct_pkg::S_DONE : pmct_pkg::S_VISIT;
      pmct_pkg::S_DONE:   if (sts_i.out_free) state_d = pmct_pkg::S_IDLE;
      default:            state_d = pmct_pkg::S_CLEAR;
    endcase
    // a register write reshapes the tree: restart the sweep
    if (sts_i.cfg_wr) state_d = pmct_pkg::S_CLEAR;
  end

  always_comb begin
    cmd_o.op   = pmct_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      pmct_pkg::S_CLEAR:  cmd_o.op = pmct_pkg::CMD_CLEAR;
      pmct_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = pmct_pkg::CMD_LOAD;
      end
      pmct_pkg::S_DOWN:   cmd_o.op = sts_i.lo_eq_hi ? pmct_pkg::CMD_LEAF : pmct_pkg::CMD_DOWN;
      pmct_pkg::S_POP:    cmd_o.op = pmct_pkg::CMD_POP;
      pmct_pkg::S_UPISS:  cmd_o.op = pmct_pkg::CMD_UPISS;
      pmct_pkg::S_UPRD:   cmd_o.op = pmct_pkg::CMD_UPRD;
      pmct_pkg::S_CAISS:  cmd_o.op = pmct_pkg::CMD_CAISS;
      pmct_pkg::S_CAEVAL: cmd_o.op = pmct_pkg::CMD_CAEVAL;
      pmct_pkg::S_UPWR:   cmd_o.op = pmct_pkg::CMD_UPWR;
      pmct_pkg::S_VISIT:  cmd_o.op = pmct_pkg::CMD_VISIT;
      pmct_pkg::S_QISS:   cmd_o.op = pmct_pkg::CMD_QISS;
      pmct_pkg::S_QMAX:   cmd_o.op = pmct_pkg::CMD_QMAX;
      pmct_pkg::S_DONE:   if (sts_i.out_free) cmd_o.op = pmct_pkg::CMD_OUT;
      default:            cmd_o.op = pmct_pkg::CMD_NONE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/pmct_dp.sv
`default_nettype none
module pmct_dp #(
  parameter int LEAVES = 1024,
  localparam int POS_W = $clog2(LEAVES) + 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pmct_pkg::cmd_t                   cmd_i,
  output pmct_pkg::sts_t                        sts_o,
  input  wire logic                             req_type_i,
  input  wire logic [POS_W-1:0]                 position_i,
  input  wire logic signed [pmct_pkg::HGT_W-1:0] new_height_i,
  input  wire logic [POS_W-1:0]                 range_left_i,
  input  wire logic [POS_W-1:0]                 range_right_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [pmct_pkg::CNT_W-1:0]            visible_count_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pmct_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [pmct_pkg::PDATA_W-1:0]     pwdata,
  output logic [pmct_pkg::PDATA_W-1:0]          prdata
);

  localparam int NODES  = 4 * LEAVES;
  localparam int ADDR_W = $clog2(NODES);
  localparam int STK_D  = $clog2(LEAVES) + 1;
  localparam int IDX_W  = $clog2(STK_D);
  localparam int SP_W   = $clog2(STK_D + 1);
  localparam int CNT_W  = pmct_pkg::CNT_W;
  localparam int HGT_W  = pmct_pkg::HGT_W;

  // configuration
  logic [POS_W-1:0] cfg_q;
  logic [POS_W-1:0] n_used;
  logic             cfg_sel, cfg_wr;

  assign cfg_sel = (paddr[pmct_pkg::PADDR_W-1:2] == pmct_pkg::REG_POSITIONS);
  assign cfg_wr  = psel && penable && pwrite && cfg_sel;
  assign prdata  = cfg_sel ? pmct_pkg::PDATA_W'(cfg_q) : '0;

  always_comb begin
    if (cfg_q == '0) begin
      n_used = POS_W'(1);
    end else if (cfg_q > POS_W'(LEAVES)) begin
      n_used = POS_W'(LEAVES);
    end else begin
      n_used = cfg_q;
    end
  end

  // node memories
  logic signed [HGT_W-1:0] mem_max [NODES];
  logic [CNT_W-1:0]        mem_vis [NODES];
  logic signed [HGT_W-1:0] rd_max_a, rd_max_b, wr_max;
  logic [CNT_W-1:0]        rd_vis_a, rd_vis_b, wr_vis;
  logic [ADDR_W-1:0]       ra, rb, wa;
  logic                    we;

  // sequencer registers
  logic [ADDR_W-1:0]       clr_q;
  logic                    out_valid_q;
  logic [CNT_W-1:0]        out_count_q;
  logic [SP_W-1:0]         sp_q;
  logic                    type_q;
  logic [POS_W-1:0]        pos_q, ql_q, qr_q, lo_q, hi_q, ca_lo_q, ca_hi_q;
  logic signed [HGT_W-1:0] val_q, run_q, ca_val_q, pmax_q;
  logic [ADDR_W-1:0]       node_q, ca_node_q;
  logic [CNT_W-1:0]        acc_q, pvis_q, cnt_q;
  logic [ADDR_W-1:0]       stk_node [STK_D];
  logic [POS_W-1:0]        stk_lo   [STK_D];
  logic [POS_W-1:0]        stk_hi   [STK_D];

  logic [POS_W:0]          sum, ca_sum;
  logic [POS_W-1:0]        mid, ca_mid, ql_c, qr_c;
  logic [ADDR_W-1:0]       lc, rc, ca_lc, ca_rc;
  logic [SP_W-1:0]         sp_m1;
  logic [IDX_W-1:0]        push_idx, pop_idx;
  logic                    split_both, go_left;

  assign sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid    = sum[POS_W:1];
  assign ca_sum = {1'b0, ca_lo_q} + {1'b0, ca_hi_q};
  assign ca_mid = ca_sum[POS_W:1];
  assign lc     = {node_q[ADDR_W-2:0], 1'b0};
  assign rc     = {node_q[ADDR_W-2:0], 1'b1};
  assign ca_lc  = {ca_node_q[ADDR_W-2:0], 1'b0};
  assign ca_rc  = {ca_node_q[ADDR_W-2:0], 1'b1};
  assign sp_m1    = sp_q - SP_W'(1);
  assign push_idx = sp_q[IDX_W-1:0];
  assign pop_idx  = sp_m1[IDX_W-1:0];

  assign ql_c = (range_left_i == '0) ? POS_W'(1) : range_left_i;
  assign qr_c = (range_right_i > n_used) ? n_used : range_right_i;

  assign split_both = (ql_q <= mid) && (qr_q > mid);
  assign go_left    = (ql_q <= mid);

  always_comb begin
    we     = 1'b0;
    wa     = node_q;
    wr_max = val_q;
    wr_vis = CNT_W'(1);
    ra     = '0;
    rb     = '0;
    case (cmd_i.op)
      pmct_pkg::CMD_CLEAR: begin
        we     = 1'b1;
        wa     = clr_q;
        wr_max = '0;
      end
      pmct_pkg::CMD_LEAF:  we = 1'b1;
      pmct_pkg::CMD_UPWR: begin
        we     = 1'b1;
        wr_max = pmax_q;
        wr_vis = pvis_q + acc_q;
      end
      pmct_pkg::CMD_UPISS: begin
        ra = lc;
        rb = rc;
      end
      pmct_pkg::CMD_CAISS: begin
        ra = ca_node_q;
        rb = ca_lc;  // unused when the node is a leaf
      end
      pmct_pkg::CMD_QISS:  ra = node_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_max[wa] <= wr_max;
      mem_vis[wa] <= wr_vis;
    end
    rd_max_a <= mem_max[ra];
    rd_vis_a <= mem_vis[ra];
    rd_max_b <= mem_max[rb];
    rd_vis_b <= mem_vis[rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= POS_W'(LEAVES);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sp_q        <= '0;
    end else begin
      if (cfg_wr) cfg_q <= pwdata[POS_W-1:0];
      if (cfg_wr) begin
        clr_q <= '0;
      end else if (cmd_i.op == pmct_pkg::CMD_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.op == pmct_pkg::CMD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        pmct_pkg::CMD_LOAD:  sp_q <= '0;
        pmct_pkg::CMD_DOWN:  sp_q <= sp_q + SP_W'(1);
        pmct_pkg::CMD_VISIT: if (!sts_o.full_cover && split_both) sp_q <= sp_q + SP_W'(1);
        pmct_pkg::CMD_POP:   sp_q <= sp_m1;
        pmct_pkg::CMD_QMAX:  if (sp_q != '0) sp_q <= sp_m1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      pmct_pkg::CMD_LOAD: begin
        type_q <= req_type_i;
        pos_q  <= position_i;
        val_q  <= new_height_i;
        ql_q   <= ql_c;
        qr_q   <= qr_c;
        node_q <= ADDR_W'(1);
        lo_q   <= POS_W'(1);
        hi_q   <= n_used;
        run_q  <= '0;
        cnt_q  <= '0;
      end
      pmct_pkg::CMD_DOWN: begin
        stk_node[push_idx] <= node_q;
        stk_lo[push_idx]   <= lo_q;
        stk_hi[push_idx]   <= hi_q;
        if (pos_q <= mid) begin
          node_q <= lc;
          hi_q   <= mid;
        end else begin
          node_q <= rc;
          lo_q   <= mid + POS_W'(1);
        end
      end
      pmct_pkg::CMD_POP: begin
        node_q <= stk_node[pop_idx];
        lo_q   <= stk_lo[pop_idx];
        hi_q   <= stk_hi[pop_idx];
      end
      pmct_pkg::CMD_UPRD: begin
        pmax_q    <= (rd_max_a > rd_max_b) ? rd_max_a : rd_max_b;
        pvis_q    <= rd_vis_a;
        ca_node_q <= rc;
        ca_lo_q   <= mid + POS_W'(1);
        ca_hi_q   <= hi_q;
        ca_val_q  <= rd_max_a;
        acc_q     <= '0;
      end
      pmct_pkg::CMD_CAEVAL: begin
        // port a holds the node, port b its left child
        if (rd_max_a <= ca_val_q) begin
          acc_q <= acc_q;
        end else if (ca_lo_q == ca_hi_q) begin
          acc_q <= acc_q + CNT_W'(1);
        end else if (rd_max_b <= ca_val_q) begin
          ca_node_q <= ca_rc;
          ca_lo_q   <= ca_mid + POS_W'(1);
        end else begin
          acc_q     <= acc_q + rd_vis_a - rd_vis_b;
          ca_node_q <= ca_lc;
          ca_hi_q   <= ca_mid;
        end
      end
      pmct_pkg::CMD_VISIT: begin
        if (sts_o.full_cover) begin
          ca_node_q <= node_q;
          ca_lo_q   <= lo_q;
          ca_hi_q   <= hi_q;
          ca_val_q  <= run_q;
          acc_q     <= '0;
        end else begin
          if (split_both) begin
            stk_node[push_idx] <= rc;
            stk_lo[push_idx]   <= mid + POS_W'(1);
            stk_hi[push_idx]   <= hi_q;
          end
          if (go_left) begin
            node_q <= lc;
            hi_q   <= mid;
          end else begin
            node_q <= rc;
            lo_q   <= mid + POS_W'(1);
          end
        end
      end
      pmct_pkg::CMD_QMAX: begin
        cnt_q <= cnt_q + acc_q;
        if (rd_max_a > run_q) run_q <= rd_max_a;
        if (sp_q != '0) begin
          node_q <= stk_node[pop_idx];
          lo_q   <= stk_lo[pop_idx];
          hi_q   <= stk_hi[pop_idx];
        end
      end
      pmct_pkg::CMD_OUT:   out_count_q <= cnt_q;
      default: ;
    endcase
  end

  assign sts_o.cfg_wr     = cfg_wr;
  assign sts_o.clr_last   = (clr_q == ADDR_W'(NODES - 1));
  assign sts_o.in_query   = (req_type_i == pmct_pkg::REQ_QUERY);
  assign sts_o.req_ok     = (req_type_i == pmct_pkg::REQ_QUERY) ? (ql_c <= qr_c)
                          : ((position_i != '0) && (position_i <= n_used));
  assign sts_o.cur_query  = (type_q == pmct_pkg::REQ_QUERY);
  assign sts_o.lo_eq_hi   = (lo_q == hi_q);
  assign sts_o.sp_zero    = (sp_q == '0);
  assign sts_o.ca_done    = (rd_max_a <= ca_val_q) || (ca_lo_q == ca_hi_q);
  assign sts_o.full_cover = (ql_q <= lo_q) && (hi_q <= qr_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign visible_count_o = out_count_q;

endmodule
`default_nettype wire

FILE: sv/prefix_maxima_count_tree.sv
`default_nettype none
// Prefix-maxima count tree: heights live in a heap-ordered segment tree held in two
// 4*LEAVES-entry node memories (maximum and visible count). After reset and after
// every write of positions_in_use the tree is swept back to all-zero heights, and no
// item is taken during the sweep. A height write walks down about log2(n) levels,
// then at each ancestor reads both children and walks the right child down again
// to recount what stays visible; each walk step issues a read on the dual-read-port
// memory and then evaluates it. With L = ceil(log2 n), a range query visits up to
// 2*L covering nodes, each with its own walk. One item is in work at a time; the
// result register lets the next item in while a query result waits.
module prefix_maxima_count_tree #(
  parameter int LEAVES = 1024,
  localparam int POS_W = $clog2(LEAVES) + 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              req_type_i,
  input  wire logic [POS_W-1:0]                  position_i,
  input  wire logic signed [pmct_pkg::HGT_W-1:0] new_height_i,
  input  wire logic [POS_W-1:0]                  range_left_i,
  input  wire logic [POS_W-1:0]                  range_right_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [pmct_pkg::CNT_W-1:0]             visible_count_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pmct_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [pmct_pkg::PDATA_W-1:0]      pwdata,
  output logic [pmct_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready
);

  pmct_pkg::cmd_t cmd;
  pmct_pkg::sts_t sts;

  assign pready = 1'b1;

  pmct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  pmct_dp #(
    .LEAVES (LEAVES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .position_i      (position_i),
    .new_height_i    (new_height_i),
    .range_left_i    (range_left_i),
    .range_right_i   (range_right_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .visible_count_o (visible_count_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
  );

`include "assert_macros.svh"

  `PMCT_ASSERT(a_query_busy, in_valid_i && in_ready_o && req_type_i == pmct_pkg::REQ_QUERY |=> !in_ready_o, "query transfer did not leave the block busy")
  `PMCT_ASSERT(a_out_from_ctrl, $rose(out_valid_o) |-> $past(cmd.op == pmct_pkg::CMD_OUT), "result appeared without an output command")
  `PMCT_ASSERT_NEVER(a_clear_no_accept, cmd.op == pmct_pkg::CMD_CLEAR && in_ready_o, "input ready during clearing sweep")

endmodule
`default_nettype wire

FILE: test/prefix_maxima_count_tree_checker.sv
`default_nettype none
module prefix_maxima_count_tree_checker #(
  parameter int LEAVES = 1024,
  localparam int POS_W = $clog2(LEAVES) + 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  input  wire logic                              in_ready_i,
  input  wire logic                              req_type_i,
  input  wire logic [POS_W-1:0]                  position_i,
  input  wire logic signed [pmct_pkg::HGT_W-1:0] new_height_i,
  input  wire logic [POS_W-1:0]                  range_left_i,
  input  wire logic [POS_W-1:0]                  range_right_i,
  input  wire logic                              out_valid_i,
  input  wire logic                              out_ready_i,
  input  wire logic [pmct_pkg::CNT_W-1:0]        visible_count_i,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pmct_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [pmct_pkg::PDATA_W-1:0]      pwdata,
  input  wire logic                              pready,
  output int                                     fail_count_o,
  output int                                     pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_CNT = 4 * LEAVES;
  localparam int CNT_W = pmct_pkg::CNT_W;
  localparam int HGT_W = pmct_pkg::HGT_W;

  logic signed [HGT_W-1:0] tree_max[NODE_CNT];
  logic [CNT_W-1:0]        tree_vis[NODE_CNT];
  logic [CNT_W-1:0]        positions_reg;
  logic signed [HGT_W-1:0] run_peak;
  logic [CNT_W-1:0]        count_q[$];

  function automatic int unsigned span_len();
    int unsigned n;
    n = positions_reg;
    if (n < 1) n = 1;
    if (n > LEAVES) n = LEAVES;
    return n;
  endfunction

  function automatic void wipe_tree();
    for (int i = 0; i < NODE_CNT; i++) begin
      tree_max[i] = '0;
      tree_vis[i] = 1;
    end
  endfunction

  // items of node's span above thr and above every earlier item of the span
  function automatic int unsigned visible_above(int unsigned node, int unsigned lo,
                                                int unsigned hi, logic signed [HGT_W-1:0] thr);
    int unsigned acc, mid, lc;
    acc = 0;
    forever begin
      if (node >= NODE_CNT) return acc;
      if (tree_max[node] <= thr) return acc;
      if (lo == hi) return acc + 1;
      mid = (lo + hi) / 2;
      lc = 2 * node;
      if (lc + 1 >= NODE_CNT) return acc;
      if (tree_max[lc] <= thr) begin
        node = lc + 1;
        lo = mid + 1;
      end else begin
        acc += int'(tree_vis[node]) - int'(tree_vis[lc]);
        node = lc;
        hi = mid;
      end
    end
  endfunction

  function automatic void set_height(int unsigned node, int unsigned lo, int unsigned hi,
                                     int unsigned pos, logic signed [HGT_W-1:0] h);
    int unsigned mid, lc, rc;
    if (node >= NODE_CNT) return;
    if (lo == hi) begin
      tree_max[node] = h;
      tree_vis[node] = 1;
      return;
    end
    mid = (lo + hi) / 2;
    lc = 2 * node;
    rc = lc + 1;
    if (rc >= NODE_CNT) return;
    if (pos <= mid) set_height(lc, lo, mid, pos, h);
    else set_height(rc, mid + 1, hi, pos, h);
    tree_max[node] = (tree_max[lc] > tree_max[rc]) ? tree_max[lc] : tree_max[rc];
    tree_vis[node] = CNT_W'(int'(tree_vis[lc]) + visible_above(rc, mid + 1, hi, tree_max[lc]));
  endfunction

  // run_peak carries the running maximum left to right across covering nodes
  function automatic int unsigned count_range(int unsigned node, int unsigned lo,
                                              int unsigned hi, int unsigned ql, int unsigned qr);
    int unsigned mid, res;
    res = 0;
    if (node >= NODE_CNT) return 0;
    if (ql <= lo && hi <= qr) begin
      res = visible_above(node, lo, hi, run_peak);
      if (tree_max[node] > run_peak) run_peak = tree_max[node];
      return res;
    end
    mid = (lo + hi) / 2;
    if (ql <= mid) res += count_range(2 * node, lo, mid, ql, qr);
    if (qr > mid) res += count_range(2 * node + 1, mid + 1, hi, ql, qr);
    return res;
  endfunction

  initial begin
    fail_count_o = 0;
    positions_reg = CNT_W'(LEAVES);
    wipe_tree();
  end

  assign pending_o = count_q.size();

  always @(posedge clk_i) begin
    int unsigned n, ql, qr, cnt;
    logic [CNT_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (count_q.size() == 0) begin
          $error("result transfer with nothing expected: visible_count=%0d", visible_count_i);
          fail_count_o++;
        end else begin
          want = count_q.pop_front();
          if (visible_count_i !== want) begin
            $error("visible_count mismatch: expected %0d, actual %0d", want, visible_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        n = span_len();
        if (req_type_i == pmct_pkg::REQ_WRITE) begin
          if (position_i >= 1 && position_i <= n) set_height(1, 1, n, position_i, new_height_i);
        end else begin
          ql = range_left_i;
          qr = range_right_i;
          if (ql < 1) ql = 1;
          if (qr > n) qr = n;
          cnt = 0;
          run_peak = '0;
          if (ql <= qr) cnt = count_range(1, 1, n, ql, qr);
          count_q.push_back(CNT_W'(cnt));
        end
      end
      if (psel && penable && pwrite && pready && paddr == {pmct_pkg::REG_POSITIONS, 2'b00}) begin
        positions_reg = pwdata[CNT_W-1:0];
        wipe_tree();
      end
    end
  end
endmodule
`default_nettype wire

FILE: test/prefix_maxima_count_tree_test.sv
`default_nettype none
module prefix_maxima_count_tree_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAVES = 1024;
  localparam int POS_W = $clog2(LEAVES) + 1;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = pmct_pkg::REQ_WRITE;
  logic [POS_W-1:0] position = '0;
  logic signed [pmct_pkg::HGT_W-1:0] new_height = '0;
  logic [POS_W-1:0] range_left = '0;
  logic [POS_W-1:0] range_right = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [pmct_pkg::CNT_W-1:0] visible_count;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pmct_pkg::PADDR_W-1:0] paddr = '0;
  logic [pmct_pkg::PDATA_W-1:0] pwdata = '0;
  logic [pmct_pkg::PDATA_W-1:0] prdata;
  logic pready;

  int fail_count, pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;
  int unsigned span = LEAVES;

  always #1 clk_i = ~clk_i;

  prefix_maxima_count_tree #(.LEAVES(LEAVES)) uut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .req_type_i(req_type), .position_i(position), .new_height_i(new_height),
    .range_left_i(range_left), .range_right_i(range_right),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .visible_count_o(visible_count),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  prefix_maxima_count_tree_checker #(.LEAVES(LEAVES)) chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .req_type_i(req_type), .position_i(position), .new_height_i(new_height),
    .range_left_i(range_left), .range_right_i(range_right),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .visible_count_i(visible_count),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or a long hold-off when hold_cycles is set
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic offer(logic kind, int unsigned pos, logic [31:0] h,
                       int unsigned l, int unsigned r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    position <= POS_W'(pos);
    new_height <= h;
    range_left <= POS_W'(l);
    range_right <= POS_W'(r);
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_positions(int unsigned v);
    while (pending != 0) @(negedge clk_i);
    // a height write with no result may still be walking the tree
    repeat (300) @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {pmct_pkg::REG_POSITIONS, 2'b00};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    span = (v < 1) ? 1 : (v > LEAVES) ? LEAVES : v;
  endtask

  task automatic random_item();
    int unsigned pos, l, r;
    logic [31:0] h;
    int unsigned pick;
    pick = $urandom_range(99);
    h = (pick < 50) ? 32'($signed($urandom_range(35)) - 5) :
        (pick < 80) ? $urandom : 32'($urandom_range(400));
    pos = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(span, 1);
    if ($urandom_range(99) < 85) begin
      l = $urandom_range(span, 1);
      r = $urandom_range(span, l);
    end else begin
      l = $urandom_range(2047);
      r = $urandom_range(2047);
    end
    if ($urandom_range(99) < 40) offer(pmct_pkg::REQ_QUERY, pos, h, l, r);
    else offer(pmct_pkg::REQ_WRITE, pos, h, l, r);
  endtask

  initial begin
    int unsigned cfg_vals[6] = '{2, 0, 2047, 37, 1, 1024};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tree, height extremes, positions and ranges at the edges
    offer(pmct_pkg::REQ_QUERY, 0, 0, 1, 1024);
    offer(pmct_pkg::REQ_WRITE, 1, 32'h7FFF_FFFF, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 1024, 32'h8000_0000, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 0, 32'd55, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 1025, 32'd66, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 2047, 32'd77, 0, 0);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 0, 2047);
    offer(pmct_pkg::REQ_WRITE, 1, 32'hFFFF_FFFF, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 2, 32'd0, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 3, 32'd5, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 4, 32'd5, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 5, 32'd9, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 512, 32'd10, 0, 0);
    offer(pmct_pkg::REQ_WRITE, 513, 32'd3, 0, 0);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 1, 1024);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 4, 513);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 513, 513);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 700, 300);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 1025, 2047);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 2047, 0);
    offer(pmct_pkg::REQ_WRITE, 1024, 32'h7FFF_FFFF, 0, 0);
    offer(pmct_pkg::REQ_QUERY, 0, 0, 1, 2047);
    @(negedge clk_i);
    in_valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      write_positions(cfg_vals[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (ph == 2) hold_cycles = 800;  // block fills up and holds its input off
      for (int i = 0; i < 180; i++) random_item();
      @(negedge clk_i);
      in_valid <= 1'b0;
    end

    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
